FILE: rtl/cmd3_pkg.sv
`default_nettype none

package cmd3_pkg;

  // Frame limits and the widths that follow from them
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 3;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int GEO_W_W = $clog2(MAX_WIDTH + 1);
  localparam int GEO_H_W = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);

  // Configuration registers
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // Pixel and window
  localparam int PIX_W   = 24;
  localparam int NBR     = 8;
  localparam int CNT_W   = 4;
  localparam int QCOL_W  = 15;
  localparam int CENTRE  = 4;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [8:0][PIX_W-1:0] pix_win_t;
  typedef logic [QCOL_W-1:0] qcol_t;

  typedef struct packed {
    logic       flush;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_chan0;
    logic [7:0] out_chan1;
    logic [7:0] out_chan2;
    logic       grew;
    logic       frame_end;
  } out_item_t;

  // Per-transaction control carried with the window
  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } win_ctl_t;

  // Top 5 bits of each channel: chan0 high, chan2 low
  function automatic qcol_t quantize(pixel_t px);
    quantize = {px[7:3], px[15:11], px[23:19]};
  endfunction

  // Expand a quantized colour back to a pixel
  function automatic pixel_t expand(qcol_t q);
    expand = {q[4:0], 3'b000, q[9:5], 3'b000, q[14:10], 3'b000};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cmd3_ram.sv
`default_nettype none

module cmd3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cmd3_window.sv
`default_nettype none

module cmd3_window
  import cmd3_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_data_i,
  output logic                       win_valid_o,
  input  wire logic                  win_ready_i,
  output win_ctl_t                   win_ctl_o,
  output pix_win_t                   win_o
);

  logic [CFG_WIDTH_W-1:0]  cfg_width_q;
  logic [CFG_HEIGHT_W-1:0] cfg_height_q;
  logic [GEO_W_W-1:0]      geo_w_q, eff_w, width_clamped;
  logic [GEO_H_W-1:0]      geo_h_q, eff_h, height_clamped;
  logic [COL_W-1:0]        col_q, col_d, qc;
  logic [ROW_W-1:0]        row_q, row_d, qr;
  logic                    frame_start, flush_slot, in_fire;
  pixel_t                  px;
  win_ctl_t                ctl;

  logic                    s1_valid_q, s1_fire;
  logic [COL_W-1:0]        s1_col_q;
  pixel_t                  s1_px_q;
  win_ctl_t                s1_ctl_q;
  logic [2*PIX_W-1:0]      rd_data, wr_data;

  logic                    win_valid_q;
  win_ctl_t                win_ctl_q;
  pix_win_t                win_q, win_d;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= FRAME_WIDTH_RST;
      cfg_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  cfg_width_q  <= cfg_data_i[CFG_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: cfg_height_q <= cfg_data_i[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp geometry; it is latched at the first slot of a frame
  always_comb begin
    if (int'(cfg_width_q) < MIN_DIM) begin
      width_clamped = GEO_W_W'(MIN_DIM);
    end else if (int'(cfg_width_q) > MAX_WIDTH) begin
      width_clamped = GEO_W_W'(MAX_WIDTH);
    end else begin
      width_clamped = GEO_W_W'(cfg_width_q);
    end
    if (int'(cfg_height_q) < MIN_DIM) begin
      height_clamped = GEO_H_W'(MIN_DIM);
    end else if (int'(cfg_height_q) > MAX_HEIGHT) begin
      height_clamped = GEO_H_W'(MAX_HEIGHT);
    end else begin
      height_clamped = GEO_H_W'(cfg_height_q);
    end
  end

  assign frame_start = (col_q == '0) && (row_q == '0);
  assign eff_w       = frame_start ? width_clamped : geo_w_q;
  assign eff_h       = frame_start ? height_clamped : geo_h_q;

  // Slot position, output position and next counters
  always_comb begin
    flush_slot = int'(row_q) >= int'(eff_h);
    px = (in_data_i.flush || flush_slot) ? '0
         : {in_data_i.chan2, in_data_i.chan1, in_data_i.chan0};
    if (col_q != '0) begin
      qr = row_q - ROW_W'(1);
      qc = col_q - COL_W'(1);
    end else begin
      qr = (int'(row_q) >= 2) ? row_q - ROW_W'(2) : '0;
      qc = COL_W'(eff_w - GEO_W_W'(1));
    end
    ctl.emit     = (int'(row_q) >= 2) || ((int'(row_q) == 1) && (col_q != '0));
    ctl.interior = (qr != '0) && (int'(qr) + 2 <= int'(eff_h))
                && (qc != '0) && (int'(qc) + 2 <= int'(eff_w));
    ctl.last     = (int'(row_q) == int'(eff_h) + 1) && (col_q == '0);
    if (int'(col_q) + 1 >= int'(eff_w)) begin
      col_d = '0;
      row_d = row_q + ROW_W'(1);
    end else begin
      col_d = col_q + COL_W'(1);
      row_d = row_q;
    end
    if (ctl.last) begin
      col_d = '0;
      row_d = '0;
    end
  end

  assign s1_fire    = s1_valid_q && (!win_valid_q || win_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // Advance counters and latch geometry per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      geo_w_q <= GEO_W_W'(FRAME_WIDTH_RST);
      geo_h_q <= GEO_H_W'(FRAME_HEIGHT_RST);
    end else if (in_fire) begin
      col_q   <= col_d;
      row_q   <= row_d;
      geo_w_q <= eff_w;
      geo_h_q <= eff_h;
    end
  end

  // Line buffer stage: upper row in the high half, middle row in the low half
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_col_q <= col_q;
      s1_px_q  <= px;
      s1_ctl_q <= ctl;
    end
  end

  // Shift middle into upper and the new pixel into middle
  assign wr_data = {rd_data[PIX_W-1:0], s1_px_q};

  cmd3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (wr_data),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (rd_data)
  );

  // Shift the 3x3 window one column
  always_comb begin
    win_d    = win_q;
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2] = rd_data[2*PIX_W-1:PIX_W];
    win_d[3] = win_q[4];
    win_d[4] = win_q[5];
    win_d[5] = rd_data[PIX_W-1:0];
    win_d[6] = win_q[7];
    win_d[7] = win_q[8];
    win_d[8] = s1_px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      win_valid_q <= 1'b0;
      win_ctl_q   <= '0;
    end else begin
      if (s1_fire) begin
        win_q       <= win_d;
        win_ctl_q   <= s1_ctl_q;
        win_valid_q <= 1'b1;
      end else if (win_ready_i) begin
        win_valid_q <= 1'b0;
      end
    end
  end

  assign win_valid_o = win_valid_q;
  assign win_ctl_o   = win_ctl_q;
  assign win_o       = win_q;

endmodule

`default_nettype wire

FILE: rtl/cmd3_vote.sv
`default_nettype none

module cmd3_vote
  import cmd3_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     win_valid_i,
  output logic          win_ready_o,
  input  wire win_ctl_t win_ctl_i,
  input  wire pix_win_t win_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_item_t     out_data_o
);

  // Stage A: quantized neighbours and pairwise matches
  logic                      a_valid_q, a_free, a_adv;
  logic                      a_emit_q, a_last_q, a_grow_q;
  pixel_t                    a_centre_q;
  qcol_t [NBR-1:0]           a_q_q, nbr_q;
  logic [NBR-1:0][NBR-1:0]   a_eq_q, eq_d;
  logic                      grow_d, filled_d;

  // Stage B: per-colour counts at first appearance
  logic                      b_valid_q, b_free, b_adv;
  logic                      b_emit_q, b_last_q, b_grow_q;
  pixel_t                    b_centre_q;
  qcol_t [NBR-1:0]           b_q_q;
  logic [NBR-1:0]            b_cand_q, cand_d;
  logic [NBR-1:0][CNT_W-1:0] b_cnt_q, cnt_d;

  // Output register
  logic                      out_valid_q, out_free;
  out_item_t                 out_q, out_d;
  logic [CNT_W-1:0]          best_cnt;
  qcol_t                     best_col;
  pixel_t                    res;

  assign out_free    = !out_valid_q || out_ready_i;
  assign b_adv       = b_valid_q && (!b_emit_q || out_free);
  assign b_free      = !b_valid_q || b_adv;
  assign a_adv       = a_valid_q && b_free;
  assign a_free      = !a_valid_q || a_adv;
  assign win_ready_o = a_free;

  // Candidate test, quantize, compare every neighbour pair
  always_comb begin
    filled_d = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (win_i[i][23:16] != 8'd0) filled_d = 1'b1;
    end
    grow_d = win_ctl_i.interior && (win_i[CENTRE][23:16] == 8'd0) && filled_d;
    for (int k = 0; k < NBR; k++) begin
      nbr_q[k] = quantize(win_i[(k < CENTRE) ? k : k + 1]);
    end
    eq_d = '0;
    for (int i = 0; i < NBR; i++) begin
      for (int j = 0; j < NBR; j++) begin
        if (j > i) eq_d[i][j] = (nbr_q[i] == nbr_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_free) begin
      a_valid_q <= win_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_free && win_valid_i) begin
      a_emit_q   <= win_ctl_i.emit;
      a_last_q   <= win_ctl_i.last;
      a_grow_q   <= grow_d;
      a_centre_q <= win_i[CENTRE];
      a_q_q      <= nbr_q;
      a_eq_q     <= eq_d;
    end
  end

  // Count each non-black colour at its first appearance
  always_comb begin
    for (int i = 0; i < NBR; i++) begin
      cand_d[i] = (a_q_q[i] != '0);
      cnt_d[i]  = CNT_W'(1);
      for (int j = 0; j < NBR; j++) begin
        if (j < i && a_eq_q[j][i]) cand_d[i] = 1'b0;
        if (j > i) cnt_d[i] = cnt_d[i] + CNT_W'(a_eq_q[i][j]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_free) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_free && a_valid_q) begin
      b_emit_q   <= a_emit_q;
      b_last_q   <= a_last_q;
      b_grow_q   <= a_grow_q;
      b_centre_q <= a_centre_q;
      b_q_q      <= a_q_q;
      b_cand_q   <= cand_d;
      b_cnt_q    <= cnt_d;
    end
  end

  // Pick the most frequent colour; later first appearance wins a tie
  always_comb begin
    best_cnt = '0;
    best_col = '0;
    for (int k = 0; k < NBR; k++) begin
      if (b_cand_q[k] && (b_cnt_q[k] >= best_cnt)) begin
        best_cnt = b_cnt_q[k];
        best_col = b_q_q[k];
      end
    end
    res = (b_grow_q && (best_cnt != '0)) ? expand(best_col) : b_centre_q;
    out_d.out_chan0 = res[7:0];
    out_d.out_chan1 = res[15:8];
    out_d.out_chan2 = res[23:16];
    out_d.grew      = b_grow_q;
    out_d.frame_end = b_last_q;
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= b_valid_q && b_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && b_valid_q && b_emit_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/colour_mode_dilation_3x3.sv
// 3x3 colour region growing over a raster stream of 24-bit pixels.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): one transaction per pixel
// slot in raster order, then frame_width+1 flush transactions per frame.
// Output channel (out_valid_o/out_ready_i/out_data_o): one result per slot
// once the window has filled; results trail the input by one row plus one
// pixel, and frame_end marks the last result of the frame.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 frame width, 1 frame height); geometry is clamped and takes effect at
// the next frame start. Write only while the block is idle.
// Timing: one transaction per cycle sustained while the receiver keeps up;
// each result follows its slot through the line RAM read at acceptance, then
// window shift, colour compare, count, select into the output register. The
// shared line RAM is read once and written once per transaction, which sets
// the one-per-cycle rate.
// Reset: counters, window and pipeline valids clear; geometry returns to
// 640x480. The line RAM is not cleared. When the receiver stalls, the
// pipeline keeps filling its empty stages, then in_ready_o drops.
`default_nettype none

module colour_mode_dilation_3x3
  import cmd3_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_data_o
);

  logic     win_valid, win_ready;
  win_ctl_t win_ctl;
  pix_win_t win;

  // Counters, line buffer and window
  cmd3_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .win_valid_o (win_valid),
    .win_ready_i (win_ready),
    .win_ctl_o   (win_ctl),
    .win_o       (win)
  );

  // Neighbour colour vote and output register
  cmd3_vote u_vote (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_valid_i (win_valid),
    .win_ready_o (win_ready),
    .win_ctl_i   (win_ctl),
    .win_i       (win),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  // Input only backs up when the output register is full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

  // The last pixel of a frame is a corner and never grows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_end) |-> !out_data_o.grew)
    else $error("frame end pixel flagged as grown");

  // A grown pixel is either unfilled or an expanded 5-bit colour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.grew) |-> (out_data_o.out_chan2[2:0] == 3'b000))
    else $error("grown pixel has stray low bits in third channel");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_colour_mode_dilation_3x3.sv
`default_nettype none

module tb_colour_mode_dilation_3x3;
  import cmd3_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 40000;
  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 100;
  localparam int SHOW_LIMIT   = 10;

  typedef enum int {
    FRAME_CLEAN,
    FRAME_NOISY,
    FRAME_BROKEN
  } frame_style_e;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;

  colour_mode_dilation_3x3 uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Pixel slots waiting to go out and results still owed by the block
  in_item_t  slot_queue[$];
  out_item_t pending_px[$];

  // Shadow of the filter state
  pixel_t                  line_up  [MAX_WIDTH] = '{default: '0};
  pixel_t                  line_mid [MAX_WIDTH] = '{default: '0};
  pixel_t                  win      [9] = '{default: '0};
  int                      col_pos = 0;
  int                      row_pos = 0;
  int                      frame_w = 640;
  int                      frame_h = 480;
  logic [CFG_WIDTH_W-1:0]  reg_width  = FRAME_WIDTH_RST;
  logic [CFG_HEIGHT_W-1:0] reg_height = FRAME_HEIGHT_RST;

  // Per-frame colour set so that windows see repeats and ties
  logic [7:0] pal_c0 [4];
  logic [7:0] pal_c1 [4];
  logic [7:0] pal_c2 [4];

  bit steady;
  int results_seen;
  int hold_left;
  bit held;
  int fault_cnt;
  int random_items;
  int cycle_cnt;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int fit_dim(int v, int hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // Result for the window centre: mode of the non-black neighbour colours
  function automatic out_item_t grow_centre(bit inner, bit is_last);
    pixel_t      centre;
    pixel_t      pick;
    logic [14:0] seen [8];
    int          tally [8];
    int          n_seen;
    int          top_cnt;
    int          i;
    int          k;
    logic [14:0] q;
    logic [14:0] top_col;
    bit          filled;
    bit          hit;
    out_item_t   r;
    r       = '0;
    centre  = win[4];
    pick    = centre;
    filled  = 1'b0;
    n_seen  = 0;
    top_cnt = 0;
    top_col = '0;
    if (inner && centre[23:16] == 8'd0) begin
      for (i = 0; i < 9; i++) if (win[i][23:16] != 8'd0) filled = 1'b1;
      if (filled) begin
        r.grew = 1'b1;
        for (i = 0; i < 9; i++) begin
          if (i != 4) begin
            q   = {win[i][7:3], win[i][15:11], win[i][23:19]};
            hit = 1'b0;
            for (k = 0; k < n_seen; k++) begin
              if (!hit && seen[k] == q) begin
                tally[k]++;
                hit = 1'b1;
              end
            end
            if (!hit) begin
              seen[n_seen]  = q;
              tally[n_seen] = 1;
              n_seen++;
            end
          end
        end
        // later first appearance wins a tie
        for (k = 0; k < n_seen; k++) begin
          if (seen[k] != '0 && tally[k] >= top_cnt) begin
            top_cnt = tally[k];
            top_col = seen[k];
          end
        end
        if (top_cnt != 0)
          pick = {top_col[4:0], 3'b000, top_col[9:5], 3'b000, top_col[14:10], 3'b000};
      end
    end
    r.out_chan0 = pick[7:0];
    r.out_chan1 = pick[15:8];
    r.out_chan2 = pick[23:16];
    r.frame_end = is_last;
    return r;
  endfunction

  // Shift one slot into the window and queue the result it produces
  function automatic void advance_window(in_item_t it);
    int     ci;
    int     ri;
    int     qr;
    int     qc;
    pixel_t px;
    pixel_t top;
    pixel_t mid;
    bit     emit;
    bit     inner;
    bit     last;
    if (col_pos == 0 && row_pos == 0) begin
      frame_w = fit_dim(int'(reg_width), MAX_WIDTH);
      frame_h = fit_dim(int'(reg_height), MAX_HEIGHT);
    end
    ci = col_pos;
    ri = row_pos;
    if (it.flush || ri >= frame_h) px = '0;
    else px = {it.chan2, it.chan1, it.chan0};
    top          = line_up[ci];
    mid          = line_mid[ci];
    line_up[ci]  = mid;
    line_mid[ci] = px;
    win[0] = win[1]; win[1] = win[2]; win[2] = top;
    win[3] = win[4]; win[4] = win[5]; win[5] = mid;
    win[6] = win[7]; win[7] = win[8]; win[8] = px;
    emit = (ri >= 2) || (ri == 1 && ci >= 1);
    if (ci >= 1) begin
      qr = ri - 1;
      qc = ci - 1;
    end else begin
      qr = (ri >= 2) ? ri - 2 : 0;
      qc = frame_w - 1;
    end
    last = (ri == frame_h + 1) && (ci == 0);
    col_pos = ci + 1;
    if (col_pos >= frame_w) begin
      col_pos = 0;
      row_pos = ri + 1;
    end
    if (last) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (emit) begin
      inner = qr >= 1 && qr + 2 <= frame_h && qc >= 1 && qc + 2 <= frame_w;
      pending_px.push_back(grow_centre(inner, last));
    end
  endfunction

  function automatic void log_fault(string msg);
    fault_cnt++;
    if (fault_cnt <= SHOW_LIMIT) $display("%s", msg);
  endfunction

  // Sender: hold each transaction until accepted, idle now and then
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) advance_window(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (slot_queue.size() != 0 && (steady || $urandom_range(99) >= 16)) begin
          in_data_i  <= slot_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once traffic is flowing
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
      held      <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!held && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      held      <= 1'b1;
    end
  end

  // Receiver: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      out_ready_i  <= 1'b0;
      results_seen <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (pending_px.size() == 0) begin
          log_fault($sformatf("unexpected result %0d: ch %h %h %h grew %b end %b",
                              results_seen, out_data_o.out_chan0, out_data_o.out_chan1,
                              out_data_o.out_chan2, out_data_o.grew, out_data_o.frame_end));
        end else begin
          want = pending_px.pop_front();
          if (out_data_o.out_chan0 !== want.out_chan0 ||
              out_data_o.out_chan1 !== want.out_chan1 ||
              out_data_o.out_chan2 !== want.out_chan2 ||
              out_data_o.grew      !== want.grew ||
              out_data_o.frame_end !== want.frame_end)
            log_fault($sformatf(
              "result %0d: expected ch %h %h %h grew %b end %b, got ch %h %h %h grew %b end %b",
              results_seen, want.out_chan0, want.out_chan1, want.out_chan2, want.grew,
              want.frame_end, out_data_o.out_chan0, out_data_o.out_chan1,
              out_data_o.out_chan2, out_data_o.grew, out_data_o.frame_end));
        end
      end
      out_ready_i <= (hold_left == 0) && (steady || $urandom_range(99) >= 16);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_px(bit fl, logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
    in_item_t it;
    it.flush = fl;
    it.chan0 = c0;
    it.chan1 = c1;
    it.chan2 = c2;
    slot_queue.push_back(it);
  endtask

  // Wait until the block has nothing in flight
  task automatic settle();
    while (slot_queue.size() != 0 || in_valid_i || pending_px.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_geometry(int w_raw, int h_raw, bit do_w, bit do_h);
    if (do_w) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= REG_FRAME_WIDTH;
      cfg_data_i  <= w_raw[CFG_DATA_W-1:0];
      reg_width    = w_raw[CFG_WIDTH_W-1:0];
    end
    if (do_h) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= REG_FRAME_HEIGHT;
      cfg_data_i  <= h_raw[CFG_DATA_W-1:0];
      reg_height   = h_raw[CFG_HEIGHT_W-1:0];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_item_t pick_pixel();
    in_item_t it;
    int       roll;
    int       p;
    it   = '0;
    roll = $urandom_range(99);
    if (roll < 40) begin
      // unfilled, sometimes with colour in the first two channels
      if ($urandom_range(3) == 0) begin
        it.chan0 = 8'($urandom);
        it.chan1 = 8'($urandom);
      end
    end else if (roll < 85) begin
      p        = $urandom_range(3);
      it.chan0 = pal_c0[p] | 8'($urandom_range(7));
      it.chan1 = pal_c1[p] | 8'($urandom_range(7));
      it.chan2 = pal_c2[p] | 8'($urandom_range(7));
    end else begin
      it.chan0 = 8'($urandom);
      it.chan1 = 8'($urandom);
      it.chan2 = 8'($urandom);
    end
    return it;
  endfunction

  // Queue one frame plus its flush tail; optionally rewrite geometry mid-frame
  task automatic send_frame(frame_style_e style, int split_at, bit counted);
    int       w;
    int       h;
    int       n_pix;
    int       n_tail;
    int       k;
    in_item_t it;
    w      = fit_dim(int'(reg_width), MAX_WIDTH);
    h      = fit_dim(int'(reg_height), MAX_HEIGHT);
    n_pix  = w * h;
    n_tail = (style == FRAME_BROKEN) ? $urandom_range(w + 3) : w + 1;
    for (k = 0; k < 4; k++) begin
      pal_c0[k] = 8'($urandom) & 8'hF8;
      pal_c1[k] = 8'($urandom) & 8'hF8;
      pal_c2[k] = 8'($urandom) & 8'hF8;
    end
    for (k = 0; k < n_pix; k++) begin
      if (k == split_at) begin
        settle();
        write_geometry(9, 6, 1'b1, 1'b1);
      end
      it = pick_pixel();
      if (style == FRAME_NOISY && $urandom_range(9) == 0) begin
        it.flush = 1'b1;
        it.chan2 = 8'($urandom);
      end
      slot_queue.push_back(it);
    end
    // mostly true flushes; some real pixels land in flush slots
    for (k = 0; k < n_tail; k++) begin
      it       = '0;
      it.flush = ($urandom_range(4) != 0);
      it.chan0 = 8'($urandom);
      it.chan1 = 8'($urandom);
      it.chan2 = 8'($urandom);
      slot_queue.push_back(it);
    end
    if (counted) random_items += n_pix + n_tail;
  endtask

  initial begin
    int           w_raw;
    int           h_raw;
    int           roll;
    frame_style_e style;
    steady       = 1'b0;
    random_items = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Smallest frame: width below range with upper data bits set, height below range
    write_geometry(13'h1800, 2, 1'b1, 1'b1);

    // Tie between three colours, flush slot inside the window, extreme channels
    push_px(1'b0, 8'hFF, 8'h00, 8'h47);
    push_px(1'b0, 8'h13, 8'hE9, 8'h01);
    push_px(1'b1, 8'hAA, 8'h55, 8'hAA);
    push_px(1'b0, 8'h13, 8'hE9, 8'h01);
    push_px(1'b0, 8'hFF, 8'hFF, 8'h00);
    push_px(1'b0, 8'h80, 8'h81, 8'hF8);
    push_px(1'b0, 8'hFF, 8'h00, 8'h47);
    push_px(1'b0, 8'h80, 8'h81, 8'hF8);
    push_px(1'b0, 8'h00, 8'hFF, 8'hFF);
    repeat (4) push_px(1'b1, 8'h00, 8'h00, 8'h00);

    // Filled neighbours that all quantize to black; pixels in the flush slots
    push_px(1'b0, 8'h07, 8'h05, 8'h03);
    push_px(1'b0, 8'h01, 8'h07, 8'h07);
    push_px(1'b0, 8'h00, 8'h00, 8'h01);
    push_px(1'b0, 8'h06, 8'h02, 8'h05);
    push_px(1'b0, 8'h00, 8'h00, 8'h00);
    push_px(1'b0, 8'h03, 8'h04, 8'h02);
    push_px(1'b0, 8'h05, 8'h01, 8'h06);
    push_px(1'b0, 8'h02, 8'h06, 8'h04);
    push_px(1'b0, 8'h04, 8'h03, 8'h07);
    repeat (4) push_px(1'b0, 8'hFF, 8'hFF, 8'hFF);
    settle();

    // Wider frame with no idling on either side; the receiver hold-off lands in here
    write_geometry(40, 6, 1'b1, 1'b1);
    steady = 1'b1;
    send_frame(FRAME_CLEAN, -1, 1'b0);
    settle();
    steady = 1'b0;

    // Geometry rewritten early in a frame only applies from the next one
    write_geometry(5, 4, 1'b1, 1'b1);
    send_frame(FRAME_CLEAN, 2, 1'b0);
    settle();
    send_frame(FRAME_CLEAN, -1, 1'b0);

    // Random frames, mostly well formed
    while (random_items < RANDOM_ITEMS) begin
      settle();
      roll  = $urandom_range(99);
      w_raw = (roll < 80) ? $urandom_range(3, 12) :
              (roll < 90) ? $urandom_range(0, 2) : $urandom_range(13, 40);
      if ($urandom_range(7) == 0) w_raw |= $urandom_range(3) << CFG_WIDTH_W;
      h_raw = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      roll  = $urandom_range(9);
      write_geometry(w_raw, h_raw, roll < 8, roll < 6 || roll == 8);
      roll  = $urandom_range(9);
      style = (roll < 7) ? FRAME_CLEAN : (roll < 9) ? FRAME_NOISY : FRAME_BROKEN;
      send_frame(style, -1, 1'b1);
    end
    settle();

    if (fault_cnt == 0 && pending_px.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/cmd3_pkg.sv
rtl/cmd3_ram.sv
rtl/cmd3_window.sv
rtl/cmd3_vote.sv
rtl/colour_mode_dilation_3x3.sv
bench/tb_colour_mode_dilation_3x3.sv
